@@ hw/rtl/chuff_pkg.sv @@
// Shared types and constants for the canonical Huffman encoder.
`timescale 1ns / 1ps
`default_nettype none

package chuff_pkg;

    localparam int MAX_CODE_LEN         = 16;
    localparam int SYMBOL_COUNT_DEFAULT = 256;
    localparam int LEN_CAP              = 16;
    localparam int LEVEL_LIMIT          = (MAX_CODE_LEN > LEN_CAP) ? LEN_CAP : MAX_CODE_LEN;
    localparam int LEN_W                = 5;
    localparam int CODE_W               = 16;
    localparam int QUEUE_DEPTH          = 2;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_ENCODE = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LEVEL_DEC = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_NO_CODE   = 2'd3
    } status_t;

    typedef struct packed {
        op_t               op;
        status_t           status;
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } item_t;

endpackage

`default_nettype wire

@@ hw/rtl/chuff_front.sv @@
// Front end: accepts beats, builds the code table and looks up codes.
`timescale 1ns / 1ps
`default_nettype none

module chuff_front
    import chuff_pkg::*;
#(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  symbol,
    input  wire logic [4:0]  code_level,
    input  wire logic [7:0]  byte_value,
    output logic             push_valid,
    input  wire logic        push_ready,
    output item_t            push_item
);

    localparam int         ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam logic [8:0] SYM_END = 9'(SYMBOL_COUNT);

    logic                      accept;
    op_t                       op_in;
    logic [ADDR_W-1:0]         sym_idx;
    logic [ADDR_W-1:0]         byte_idx;
    logic                      sym_in_range;
    logic                      byte_in_range;
    logic [4:0]                level_diff;
    logic [32:0]               shifted;
    logic                      code_fits;
    status_t                   status_in;
    logic                      load_ok;

    logic [16:0]               next_code_reg;
    logic [16:0]               next_code_next;
    logic [4:0]                cur_level_reg;
    logic [4:0]                cur_level_next;
    logic [SYMBOL_COUNT-1:0]   valid_reg;
    logic [LEN_W+CODE_W-1:0]   code_mem [SYMBOL_COUNT];
    logic [LEN_W+CODE_W-1:0]   rd_data_reg;
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    op_t                       s1_op_reg;
    status_t                   s1_status_reg;

    assign accept        = in_valid && in_ready;
    assign op_in         = op_t'(operation);
    assign sym_idx       = symbol[ADDR_W-1:0];
    assign byte_idx      = byte_value[ADDR_W-1:0];
    assign sym_in_range  = {1'b0, symbol} < SYM_END;
    assign byte_in_range = {1'b0, byte_value} < SYM_END;

    // The running code is widened so that the fit check sees every shifted-out bit.
    always_comb
    begin
        level_diff = code_level - cur_level_reg;
        shifted    = 33'(next_code_reg) << level_diff;
        code_fits  = shifted < (33'd1 << code_level);
        status_in  = ST_OK;
        unique case (op_in)
            OP_LOAD:
            begin
                if (code_level > 5'(LEVEL_LIMIT))
                begin
                    status_in = ST_TOO_LONG;
                end
                else if (!sym_in_range)
                begin
                    status_in = ST_NO_CODE;
                end
                else if (code_level < cur_level_reg)
                begin
                    status_in = ST_LEVEL_DEC;
                end
                else if (!code_fits)
                begin
                    status_in = ST_TOO_LONG;
                end
            end
            OP_ENCODE:
            begin
                if (!byte_in_range || !valid_reg[byte_idx])
                begin
                    status_in = ST_NO_CODE;
                end
            end
            default:
            begin
                status_in = ST_OK;
            end
        endcase
    end

    assign load_ok = accept && (op_in == OP_LOAD) && (status_in == ST_OK);

    always_comb
    begin
        next_code_next = next_code_reg;
        cur_level_next = cur_level_reg;
        if (accept && (op_in == OP_START))
        begin
            next_code_next = '0;
            cur_level_next = '0;
        end
        else if (load_ok)
        begin
            next_code_next = 17'(shifted + 33'd1);
            cur_level_next = code_level;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_code_reg <= '0;
            cur_level_reg <= '0;
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            next_code_reg <= next_code_next;
            cur_level_reg <= cur_level_next;
            s1_valid_reg  <= s1_valid_next;
            if (accept && (op_in == OP_START))
            begin
                valid_reg <= '0;
            end
            else if (load_ok)
            begin
                valid_reg[sym_idx] <= 1'b1;
            end
        end
    end

    // A load and a following lookup of the same symbol fall on different edges,
    // so the lookup always sees the fresh entry.
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            code_mem[sym_idx] <= {code_level, shifted[CODE_W-1:0]};
        end
        if (accept)
        begin
            rd_data_reg   <= code_mem[byte_idx];
            s1_op_reg     <= op_in;
            s1_status_reg <= status_in;
        end
    end

    assign in_ready         = !s1_valid_reg || push_ready;
    assign push_valid       = s1_valid_reg;
    assign push_item.op     = s1_op_reg;
    assign push_item.status = s1_status_reg;
    assign push_item.hit    = (s1_op_reg == OP_ENCODE) && (s1_status_reg == ST_OK);
    assign push_item.len    = rd_data_reg[LEN_W+CODE_W-1:CODE_W];
    assign push_item.code   = rd_data_reg[CODE_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/chuff_queue.sv @@
// Short FIFO between the table front end and the bit packer.
`timescale 1ns / 1ps
`default_nettype none

module chuff_queue
    import chuff_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire item_t push_item,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output item_t     pop_item
);

    localparam int                PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int                CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(QUEUE_DEPTH);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/chuff_back.sv @@
// Back end: MSB-first bit packer and registered result output.
`timescale 1ns / 1ps
`default_nettype none

module chuff_back
    import chuff_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  wire item_t pop_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic       has_byte,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last
);

    logic [6:0]   acc_reg;
    logic [6:0]   acc_next;
    logic [2:0]   cnt_reg;
    logic [2:0]   cnt_next;
    logic         phase_reg;
    logic         out_valid_reg;
    logic         has_byte_reg;
    logic [7:0]   out_byte_reg;
    status_t      status_reg;
    logic         last_reg;

    logic [4:0]   total_bits;
    logic [22:0]  word;
    logic [22:0]  rem_mask;
    logic [7:0]   enc_byte0;
    logic [7:0]   enc_byte1;
    logic [7:0]   flush_byte;
    logic [1:0]   nbytes;
    logic [7:0]   byte_a;
    logic [7:0]   byte_b;
    logic [6:0]   item_acc;
    logic [2:0]   item_cnt;
    logic         res_has;
    logic         res_last;
    logic [7:0]   res_byte;
    logic         out_load;
    logic         take;

    // Pending bits sit above the new code; at most 23 bits, so at most two bytes.
    always_comb
    begin
        total_bits = 5'(cnt_reg) + pop_item.len;
        word       = (23'(acc_reg) << pop_item.len) | 23'(pop_item.code);
        rem_mask   = (23'd1 << total_bits[2:0]) - 23'd1;
        enc_byte0  = 8'(word >> (total_bits - 5'd8));
        enc_byte1  = 8'(word >> (total_bits - 5'd16));
        flush_byte = 8'(15'(acc_reg) << (4'd8 - 4'(cnt_reg)));
    end

    always_comb
    begin
        nbytes   = 2'd0;
        byte_a   = enc_byte0;
        byte_b   = enc_byte1;
        item_acc = acc_reg;
        item_cnt = cnt_reg;
        unique case (pop_item.op)
            OP_ENCODE:
            begin
                if (pop_item.hit)
                begin
                    nbytes   = total_bits[4:3];
                    item_acc = 7'(word & rem_mask);
                    item_cnt = total_bits[2:0];
                end
            end
            OP_FLUSH:
            begin
                byte_a   = flush_byte;
                nbytes   = (cnt_reg != 3'd0) ? 2'd1 : 2'd0;
                item_acc = '0;
                item_cnt = '0;
            end
            default:
            begin
                nbytes = 2'd0;
            end
        endcase
    end

    assign res_has   = nbytes != 2'd0;
    assign res_last  = !((nbytes == 2'd2) && !phase_reg);
    assign res_byte  = !res_has ? 8'd0 : (phase_reg ? byte_b : byte_a);
    assign out_load  = !out_valid_reg || out_ready;
    assign take      = pop_valid && out_load;
    assign pop_ready = out_load && res_last;

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (take && res_last)
        begin
            acc_next = item_acc;
            cnt_next = item_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            if (take)
            begin
                phase_reg     <= !res_last;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            has_byte_reg <= res_has;
            out_byte_reg <= res_byte;
            status_reg   <= pop_item.status;
            last_reg     <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign has_byte  = has_byte_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/canonical_huffman_encoder_core.sv @@
// Canonical Huffman encoder: code table build, code lookup and MSB-first byte packing.
// Path: an item's first result beat passes the front-end lookup register, a queue entry and the
// packer's output register. Throughput: one result beat per cycle while out_ready holds; an
// item whose code completes two bytes gives two beats and every other item one.
// Reset: asynchronous; clears the packer, the canonical code generator and all table valid
// bits at once, with no clearing pass; the block accepts items as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module canonical_huffman_encoder_core
    import chuff_pkg::*;
#(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  symbol,
    input  wire logic [4:0]  code_level,
    input  wire logic [7:0]  byte_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             has_byte,
    output logic [7:0]       out_byte,
    output logic [1:0]       status,
    output logic             last
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    chuff_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .symbol     (symbol),
        .code_level (code_level),
        .byte_value (byte_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    chuff_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    chuff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .has_byte  (has_byte),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

`ifndef NO_ASSERTIONS
    // The second byte of an item follows its first beat at once, with the same status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && has_byte && status == $past(status))
        else $error("second result beat missing or status changed");

    // A beat without a byte is always the only beat of its item and carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> last && out_byte == 8'd0)
        else $error("empty result beat is not a lone zero beat");

    // Only a successful lookup may reach the packer as a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_item.hit |-> pop_item.op == OP_ENCODE && pop_item.status == ST_OK)
        else $error("packer given a hit that is not a clean lookup");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the canonical Huffman encoder core.
`timescale 1ns / 1ps

module testbench
    import chuff_pkg::*;
();

    localparam int SYMBOLS     = SYMBOL_COUNT_DEFAULT;
    localparam int ITEM_TARGET = 860;
    localparam int QUIET_ITEMS = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        status_t    status;
        logic       last;
    } beat_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] operation;
    logic [7:0] symbol;
    logic [4:0] code_level;
    logic [7:0] byte_value;
    logic       out_valid;
    logic       out_ready;
    logic       has_byte;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    // Predicted encoder state.
    logic        tbl_valid [SYMBOLS];
    logic [4:0]  tbl_len   [SYMBOLS];
    logic [15:0] tbl_code  [SYMBOLS];
    logic [16:0] run_code;
    logic [4:0]  run_level;
    logic [6:0]  pend_bits;
    logic [2:0]  pend_cnt;

    beat_t       beats_due [$];
    logic [7:0]  live_syms [$];

    int mismatches      = 0;
    int items_sent      = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 20;
    int sink_busy_pct   = 20;
    int sink_gap        = 0;
    int hold_left       = 0;
    bit quiet_tail      = 1'b0;

    canonical_huffman_encoder_core #(
        .SYMBOL_COUNT(SYMBOLS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .symbol     (symbol),
        .code_level (code_level),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .has_byte   (has_byte),
        .out_byte   (out_byte),
        .status     (status),
        .last       (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, beats_due.size());
            $display("** canonical_huffman_encoder_core: FAILED **");
            $finish;
        end
    end

    task automatic reset_model();
        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_len[i]   = '0;
            tbl_code[i]  = '0;
        end
        run_code  = '0;
        run_level = '0;
        pend_bits = '0;
        pend_cnt  = '0;
    endtask

    // Works out the beats one accepted item causes and queues them.
    task automatic predict_beats(input op_t op, input logic [7:0] sym,
                                 input logic [4:0] lvl, input logic [7:0] bv);
        logic [7:0]      made [2];
        int              n;
        status_t         st;
        logic [7:0]      acc;
        logic [3:0]      cnt;
        longint unsigned cw;
        n  = 0;
        st = ST_OK;
        case (op)
            OP_START:
            begin
                foreach (tbl_valid[i])
                    tbl_valid[i] = 1'b0;
                run_code  = '0;
                run_level = '0;
            end
            OP_LOAD:
            begin
                if (lvl > LEVEL_LIMIT)
                    st = ST_TOO_LONG;
                else if (int'(sym) >= SYMBOLS)
                    st = ST_NO_CODE;
                else if (lvl < run_level)
                    st = ST_LEVEL_DEC;
                else
                begin
                    cw = longint'(run_code) << (lvl - run_level);
                    if (cw >= (64'd1 << lvl))
                        st = ST_TOO_LONG;
                    else
                    begin
                        tbl_valid[sym] = 1'b1;
                        tbl_len[sym]   = lvl;
                        tbl_code[sym]  = cw[15:0];
                        run_code       = 17'(cw + 1);
                        run_level      = lvl;
                    end
                end
            end
            OP_ENCODE:
            begin
                if (int'(bv) >= SYMBOLS || !tbl_valid[bv])
                    st = ST_NO_CODE;
                else
                begin
                    acc = {1'b0, pend_bits};
                    cnt = {1'b0, pend_cnt};
                    for (int i = tbl_len[bv]; i > 0; i--)
                    begin
                        acc = {acc[6:0], tbl_code[bv][i-1]};
                        cnt++;
                        if (cnt == 4'd8)
                        begin
                            made[n] = acc;
                            n++;
                            acc = '0;
                            cnt = '0;
                        end
                    end
                    pend_bits = acc[6:0];
                    pend_cnt  = cnt[2:0];
                end
            end
            default:
            begin
                if (pend_cnt != 3'd0)
                begin
                    acc     = {1'b0, pend_bits};
                    acc     = acc << (8 - pend_cnt);
                    made[0] = acc;
                    n       = 1;
                end
                pend_bits = '0;
                pend_cnt  = '0;
            end
        endcase
        if (n == 0)
            beats_due.push_back('{1'b0, 8'h00, st, 1'b1});
        else
            for (int k = 0; k < n; k++)
                beats_due.push_back('{1'b1, made[k], st, k == n - 1});
    endtask

    task automatic flag_mismatch(input string what, input beat_t want, input beat_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $write("%0t: %s: expected has=%0b byte=%02h status=%0d last=%0b, ",
                   $realtime, what, want.has_byte, want.out_byte, want.status, want.last);
            $display("got has=%0b byte=%02h status=%0d last=%0b",
                     got.has_byte, got.out_byte, got.status, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{has_byte, out_byte, status_t'(status), last};
            if (beats_due.size() == 0)
                flag_mismatch("beat with nothing expected", '0, got);
            else
            begin
                want = beats_due.pop_front();
                if (got !== want)
                    flag_mismatch("beat mismatch", want, got);
            end
        end
    end

    // Output side: random stalls, plus a long hold when one is requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!quiet_tail && sink_gap > 0)
            begin
                out_ready <= 1'b0;
                sink_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 99) < sink_busy_pct)
                    sink_gap = $urandom_range(1, 16);
            end
        end
    end

    task automatic send_item(input op_t op, input logic [7:0] sym,
                             input logic [4:0] lvl, input logic [7:0] bv);
        int gap;
        if (!quiet_tail && $urandom_range(0, 99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 16);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        symbol     <= sym;
        code_level <= lvl;
        byte_value <= bv;
        do
            @(posedge clk);
        while (!in_ready);
        predict_beats(op, sym, lvl, bv);
        items_sent++;
    endtask

    // Fields that an operation ignores still carry random values.
    task automatic do_start();
        send_item(OP_START, 8'($urandom), 5'($urandom), 8'($urandom));
    endtask

    task automatic do_load(input logic [7:0] sym, input logic [4:0] lvl);
        send_item(OP_LOAD, sym, lvl, 8'($urandom));
    endtask

    task automatic do_encode(input logic [7:0] bv);
        send_item(OP_ENCODE, 8'($urandom), 5'($urandom), bv);
    endtask

    task automatic do_flush();
        send_item(OP_FLUSH, 8'($urandom), 5'($urandom), 8'($urandom));
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // A single symbol at level zero exhausts the code space at once.
    task automatic test_level_zero();
        do_start();
        do_load(8'h00, 5'd0);
        do_load(8'h01, 5'd0);
        do_encode(8'h00);
        do_encode(8'h01);
        do_flush();
    endtask

    task automatic test_code_table();
        do_start();
        do_load(8'h41, 5'd17);
        do_load(8'h42, 5'd31);
        do_load(8'h41, 5'd2);
        do_load(8'h42, 5'd2);
        do_load(8'h43, 5'd3);
        do_load(8'h44, 5'd1);
        do_load(8'h41, 5'd3);
        do_load(8'hFF, 5'd16);
        do_load(8'h00, 5'd16);
        // Three pending bits ahead of a 16-bit code complete two bytes in one item.
        do_encode(8'h43);
        do_encode(8'hFF);
        do_encode(8'h41);
        do_encode(8'h00);
        do_encode(8'h42);
        do_flush();
        do_flush();
        // A new table leaves the packer alone, so the pending bits survive it.
        do_encode(8'h43);
        do_start();
        do_encode(8'hFF);
        do_flush();
    endtask

    task automatic test_output_hold();
        sender_idle_pct = 0;
        sink_busy_pct   = 0;
        do_start();
        for (int k = 0; k < 12; k++)
            do_load(8'(k * 17), (k < 4) ? 5'd4 : 5'd16);
        hold_left = 300;
        repeat (40)
            do_encode(8'(17 * $urandom_range(0, 11)));
        do_flush();
        while (hold_left > 0)
            @(posedge clk);
    endtask

    task automatic build_random_table();
        int              lvl;
        longint unsigned cand;
        logic [7:0]      sym;
        live_syms.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            do_start();
            sym = 8'($urandom);
            do_load(sym, 5'd0);
            live_syms.push_back(sym);
        end
        else
        begin
            // Now and then the loads go on from the previous table.
            if ($urandom_range(0, 9) != 0)
                do_start();
            lvl = $urandom_range(1, 8);
            repeat ($urandom_range(2, 40))
            begin
                sym = 8'($urandom);
                if (lvl < run_level)
                    lvl = run_level;
                cand = longint'(run_code) << (lvl - run_level);
                if (lvl < 16 && (cand + 1 >= (64'd1 << lvl) || $urandom_range(0, 5) == 0))
                    lvl++;
                if ($urandom_range(0, 24) == 0)
                    do_load(sym, 5'($urandom_range(17, 31)));
                else if ($urandom_range(0, 24) == 0 && run_level > 0)
                    do_load(sym, run_level - 5'd1);
                else
                    do_load(sym, 5'(lvl));
                if (tbl_valid[sym])
                    live_syms.push_back(sym);
            end
        end
    endtask

    task automatic encode_stream();
        int r;
        repeat ($urandom_range(10, 60))
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                do_flush();
            else if (r < 11)
                send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 5'($urandom),
                          8'($urandom));
            else if (r < 90 && live_syms.size() > 0)
                do_encode(live_syms[$urandom_range(0, live_syms.size() - 1)]);
            else
                do_encode(8'($urandom));
        end
    endtask

    task automatic test_random_streams();
        while (items_sent < ITEM_TARGET)
        begin
            quiet_tail      = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
            sender_idle_pct = pick_idle_pct();
            sink_busy_pct   = pick_idle_pct();
            build_random_table();
            encode_stream();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_START;
        symbol     = '0;
        code_level = '0;
        byte_value = '0;
        reset_model();
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_level_zero();
        test_code_table();
        test_output_hold();
        test_random_streams();

        @(negedge clk);
        in_valid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("** canonical_huffman_encoder_core: PASSED **");
        else
            $display("** canonical_huffman_encoder_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/chuff_pkg.sv
hw/rtl/chuff_front.sv
hw/rtl/chuff_queue.sv
hw/rtl/chuff_back.sv
hw/rtl/canonical_huffman_encoder_core.sv
sim/testbench.sv
